// File: design/ucrr_pkg.sv
// ----------------------------------------------------------------------------
// ucrr_pkg
// Shared types, codes and descriptor tables of the control request responder.
// ----------------------------------------------------------------------------
package ucrr_pkg;

    localparam int P_EP0_PACKET = 8;
    localparam int QDEPTH       = 2;

    localparam logic [2:0] EV_SETUP     = 3'd0;
    localparam logic [2:0] EV_IN_DONE   = 3'd1;
    localparam logic [2:0] EV_EP1_OUT   = 3'd3;
    localparam logic [2:0] EV_BUS_RESET = 3'd4;

    localparam logic [2:0] CMD_WR_EP0    = 3'd0;
    localparam logic [2:0] CMD_ENDP7     = 3'd1;
    localparam logic [2:0] CMD_ENDP6     = 3'd2;
    localparam logic [2:0] CMD_ENDP5     = 3'd3;
    localparam logic [2:0] CMD_ENDP4     = 3'd4;
    localparam logic [2:0] CMD_ENDP3     = 3'd5;
    localparam logic [2:0] CMD_SET_ADDR  = 3'd6;
    localparam logic [2:0] CMD_UNLOCK    = 3'd7;

    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_GET_IFACE     = 8'h0A;

    localparam logic [7:0] MASK_CLASS     = 8'h20;
    localparam logic [7:0] MASK_TYPE      = 8'h60;
    localparam logic [7:0] MASK_RECIP     = 8'h1F;
    localparam logic [7:0] RECIP_ENDP     = 8'h02;
    localparam logic [7:0] CLASS_SET_REP  = 8'h09;

    localparam logic [7:0] EP_IN2  = 8'h82;
    localparam logic [7:0] EP_OUT2 = 8'h02;
    localparam logic [7:0] EP_IN1  = 8'h81;
    localparam logic [7:0] EP_OUT1 = 8'h01;
    localparam logic [7:0] EP_IN_CLEAR  = 8'h8E;
    localparam logic [7:0] EP_OUT_CLEAR = 8'h80;
    localparam logic [7:0] EP0_STALL    = 8'h0F;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam logic [1:0] SEL_DEV = 2'd0;
    localparam logic [1:0] SEL_CFG = 2'd1;
    localparam logic [1:0] SEL_HID = 2'd2;

    localparam logic [7:0] DEV_TAB [0:17] = '{
        8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08, 8'h3c,
        8'h41, 8'h03, 8'h20, 8'h00, 8'h02, 8'h01, 8'h02, 8'h00, 8'h01};
    localparam logic [7:0] CFG_TAB [0:33] = '{
        8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h04, 8'ha0, 8'h23,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h05,
        8'h09, 8'h21, 8'h10, 8'h01, 8'h00, 8'h01, 8'h22, 8'h41, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h18};
    localparam logic [7:0] HID_TAB [0:64] = '{
        8'h05, 8'h01, 8'h09, 8'h06, 8'ha1, 8'h01, 8'h05, 8'h07, 8'h19, 8'he0,
        8'h29, 8'he7, 8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08,
        8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h03,
        8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h03, 8'h91, 8'h02,
        8'h95, 8'h01, 8'h75, 8'h05, 8'h91, 8'h01, 8'h95, 8'h06, 8'h75, 8'h08,
        8'h15, 8'h00, 8'h26, 8'hff, 8'h00, 8'h05, 8'h07, 8'h19, 8'h00, 8'h2a,
        8'hff, 8'h00, 8'h81, 8'h00, 8'hc0};

    typedef struct packed {
        logic cfg;
        logic err;
        logic rpt;
    } t_flags;

    typedef struct packed {
        logic       has_ep;
        logic [2:0] ep_cmd;
        logic [7:0] ep_data;
        logic       has_chunk;
        logic [7:0] len;
        logic       has_stall;
        logic       has_addr;
        logic [7:0] addr;
        logic       has_unlock;
        t_flags     flags;
    } t_job;

    typedef enum logic [3:0] {
        PH_EP_CMD     = 4'd0,
        PH_EP_DATA    = 4'd1,
        PH_CH_CMD     = 4'd2,
        PH_CH_LEN     = 4'd3,
        PH_CH_BYTE    = 4'd4,
        PH_STALL_CMD  = 4'd5,
        PH_STALL_DATA = 4'd6,
        PH_ADDR_CMD   = 4'd7,
        PH_ADDR_DATA  = 4'd8,
        PH_UNLOCK     = 4'd9,
        PH_IDLE       = 4'd10
    } t_phase;

    function automatic logic [7:0] f_table_byte(input logic [1:0] sel,
                                                input logic [8:0] off);
        logic [7:0] b;
        b = 8'h00;
        case (sel)
            SEL_DEV: if (off < 9'd18) b = DEV_TAB[off[4:0]];
            SEL_CFG: if (off < 9'd34) b = CFG_TAB[off[5:0]];
            SEL_HID: if (off < 9'd65) b = HID_TAB[off[6:0]];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: design/ucrr_front.sv
// ----------------------------------------------------------------------------
// ucrr_front
// Decodes requests, updates device state, queues write jobs but for EP1 out.
// ----------------------------------------------------------------------------
module ucrr_front #(
    parameter int EP0_PACKET = ucrr_pkg::P_EP0_PACKET
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [2:0]                       i_req_type,
    input  logic [3:0]                       i_setup_count,
    input  logic [7:0][7:0]                  i_bytes,
    output logic                             o_push,
    output ucrr_pkg::t_job                   o_job,
    output logic [EP0_PACKET-1:0][7:0]       o_chunk
);
    import ucrr_pkg::*;

    localparam logic [8:0] PKT9 = 9'(EP0_PACKET);
    localparam logic [7:0] PKT8 = 8'(EP0_PACKET);

    logic [EP0_PACKET-1:0][7:0] r_buf, n_buf;
    logic [7:0] r_rem, n_rem, r_doff, n_doff, r_lsr, n_lsr, r_paddr, n_paddr;
    logic [1:0] r_dsel, n_dsel, l_sel;
    logic       r_err, n_err, r_cfg, n_cfg, r_rpt, n_rpt;
    logic       l_load, l_chunk;
    logic [7:0] l_base, l_len;
    logic [8:0] l_sum;
    logic [7:0] b0, b1;

    assign b0 = i_bytes[0];
    assign b1 = i_bytes[1];

    always_comb begin
        n_buf   = r_buf;
        n_rem   = r_rem;
        n_doff  = r_doff;
        n_lsr   = r_lsr;
        n_paddr = r_paddr;
        n_dsel  = r_dsel;
        n_err   = r_err;
        n_cfg   = r_cfg;
        n_rpt   = r_rpt;
        l_load  = 1'b0;
        l_chunk = 1'b0;
        l_sel   = r_dsel;
        l_base  = r_doff;
        l_len   = 8'd0;
        l_sum   = 9'd0;
        o_job   = '0;
        case (i_req_type)
            EV_SETUP: begin
                for (int i = 0; i < 8; i++) begin
                    if (4'(i) < i_setup_count) n_buf[i] = i_bytes[i];
                end
                if (i_setup_count != 4'd8) begin
                    n_err = 1'b1;
                end else begin
                    n_rem = i_bytes[6];
                    if (((b0 & MASK_CLASS) != 8'd0) && b1 == CLASS_SET_REP) n_rpt = 1'b1;
                    if ((b0 & MASK_TYPE) == 8'd0) begin
                        n_lsr = b1;
                        case (b1)
                            REQ_CLEAR_FEATURE: begin
                                if ((b0 & MASK_RECIP) == RECIP_ENDP) begin
                                    case (i_bytes[4])
                                        EP_IN2: begin
                                            o_job.has_ep = 1'b1;
                                            o_job.ep_cmd = CMD_ENDP7;
                                            o_job.ep_data = EP_IN_CLEAR;
                                        end
                                        EP_OUT2: begin
                                            o_job.has_ep = 1'b1;
                                            o_job.ep_cmd = CMD_ENDP6;
                                            o_job.ep_data = EP_OUT_CLEAR;
                                        end
                                        EP_IN1: begin
                                            o_job.has_ep = 1'b1;
                                            o_job.ep_cmd = CMD_ENDP5;
                                            o_job.ep_data = EP_IN_CLEAR;
                                        end
                                        EP_OUT1: begin
                                            o_job.has_ep = 1'b1;
                                            o_job.ep_cmd = CMD_ENDP4;
                                            o_job.ep_data = EP_OUT_CLEAR;
                                        end
                                        default: o_job.has_ep = 1'b0;
                                    endcase
                                end else begin
                                    n_err = 1'b1;
                                end
                            end
                            REQ_GET_STATUS: begin
                                n_buf[0] = 8'd0;
                                n_buf[1] = 8'd0;
                            end
                            REQ_SET_ADDRESS: n_paddr = i_bytes[2];
                            REQ_GET_DESC: begin
                                if (i_bytes[3] == DT_DEVICE || i_bytes[3] == DT_CONFIG ||
                                    i_bytes[3] == DT_REPORT) begin
                                    n_dsel = (i_bytes[3] == DT_DEVICE) ? SEL_DEV :
                                             (i_bytes[3] == DT_CONFIG) ? SEL_CFG : SEL_HID;
                                    l_sel  = n_dsel;
                                    l_base = 8'd0;
                                    l_load = 1'b1;
                                end else begin
                                    n_err = 1'b1;
                                end
                            end
                            REQ_GET_CONFIG: n_buf[0] = {7'd0, r_cfg};
                            REQ_SET_CONFIG: n_cfg = (i_bytes[2] != 8'd0);
                            REQ_GET_IFACE:  n_buf[0] = 8'd1;
                            default: n_err = 1'b1;
                        endcase
                    end
                end
                l_chunk = !n_err;
                o_job.has_stall = n_err;
            end
            EV_IN_DONE: begin
                if (r_lsr == REQ_GET_DESC) begin
                    l_load  = 1'b1;
                    l_chunk = 1'b1;
                end else if (r_lsr == REQ_SET_ADDRESS) begin
                    o_job.has_addr = 1'b1;
                    o_job.addr     = r_paddr;
                end
                o_job.has_unlock = 1'b1;
            end
            EV_EP1_OUT: o_job.has_unlock = 1'b0;
            EV_BUS_RESET: begin
                n_err = 1'b0;
                n_cfg = 1'b0;
                n_rem = 8'd0;
                o_job.has_unlock = 1'b1;
            end
            default: o_job.has_unlock = 1'b1;
        endcase
        if (l_load) begin
            for (int k = 0; k < EP0_PACKET; k++) begin
                n_buf[k] = f_table_byte(l_sel, {1'b0, l_base} + 9'(k));
            end
            l_sum  = {1'b0, l_base} + PKT9;
            n_doff = l_sum[8] ? 8'hFF : l_sum[7:0];
        end
        if (l_chunk) begin
            l_len = (n_rem <= PKT8) ? n_rem : PKT8;
            n_rem = n_rem - l_len;
        end
        o_job.has_chunk = l_chunk;
        o_job.len       = l_len;
        o_job.flags     = '{cfg: n_cfg, err: n_err, rpt: n_rpt};
    end

    assign o_push  = i_accept && (i_req_type != EV_EP1_OUT);
    assign o_chunk = n_buf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_rem   <= 8'd0;
            r_doff  <= 8'd0;
            r_lsr   <= 8'd0;
            r_paddr <= 8'd0;
            r_dsel  <= SEL_DEV;
            r_err   <= 1'b0;
            r_cfg   <= 1'b0;
            r_rpt   <= 1'b0;
        end else if (i_accept) begin
            r_buf   <= n_buf;
            r_rem   <= n_rem;
            r_doff  <= n_doff;
            r_lsr   <= n_lsr;
            r_paddr <= n_paddr;
            r_dsel  <= n_dsel;
            r_err   <= n_err;
            r_cfg   <= n_cfg;
            r_rpt   <= n_rpt;
        end
    end

endmodule

// File: design/ucrr_queue.sv
// ----------------------------------------------------------------------------
// ucrr_queue
// Short job queue between the request decoder and the write sequencer.
// ----------------------------------------------------------------------------
module ucrr_queue #(
    parameter int EP0_PACKET = ucrr_pkg::P_EP0_PACKET
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  ucrr_pkg::t_job               i_job,
    input  logic [EP0_PACKET-1:0][7:0]   i_chunk,
    input  logic                         i_pop,
    output ucrr_pkg::t_job               o_job,
    output logic [EP0_PACKET-1:0][7:0]   o_chunk,
    output logic                         o_empty,
    output logic                         o_full
);
    import ucrr_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_job                       r_job   [QDEPTH];
    logic [EP0_PACKET-1:0][7:0] r_chunk [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_job   = r_job[r_rp];
    assign o_chunk = r_chunk[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wp]   <= i_job;
            r_chunk[r_wp] <= i_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// File: design/ucrr_back.sv
// ----------------------------------------------------------------------------
// ucrr_back
// Sequences one queued job into chip command and data writes.
// ----------------------------------------------------------------------------
module ucrr_back #(
    parameter int EP0_PACKET = ucrr_pkg::P_EP0_PACKET
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ucrr_pkg::t_job               i_job,
    input  logic [EP0_PACKET-1:0][7:0]   i_chunk,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_out_kind,
    output logic [2:0]                   o_out_command,
    output logic [7:0]                   o_out_data,
    output logic                         o_out_last,
    output ucrr_pkg::t_flags             o_flags
);
    import ucrr_pkg::*;

    localparam int IW = (EP0_PACKET > 1) ? $clog2(EP0_PACKET) : 1;

    t_phase r_state, n_state, l_cur, l_nxt;
    logic [IW-1:0] r_idx, n_idx;
    logic [9:0] l_en;
    logic l_adv;
    logic r_ovalid, r_kind, r_last;
    logic [2:0] r_cmd;
    logic [7:0] r_data;
    t_flags r_flags;
    logic l_kind;
    logic [2:0] l_cmd;
    logic [7:0] l_data;

    always_comb begin
        l_en = {i_job.has_unlock, i_job.has_addr, i_job.has_addr,
                i_job.has_stall, i_job.has_stall,
                i_job.has_chunk && (i_job.len != 8'd0), i_job.has_chunk,
                i_job.has_chunk, i_job.has_ep, i_job.has_ep};
        l_cur = r_state;
        if (r_state == PH_IDLE) begin
            for (int k = 9; k >= 0; k--) begin
                if (l_en[k]) l_cur = t_phase'(4'(k));
            end
        end
        l_nxt = PH_IDLE;
        for (int k = 9; k >= 0; k--) begin
            if (l_en[k] && 4'(k) > l_cur) l_nxt = t_phase'(4'(k));
        end
        if (l_cur == PH_CH_BYTE && (8'(r_idx) + 8'd1) < i_job.len) l_nxt = PH_CH_BYTE;
    end

    assign l_adv = !i_empty && (!r_ovalid || i_out_ready);
    assign o_pop = l_adv && (l_nxt == PH_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (l_adv) begin
            n_state = l_nxt;
            n_idx   = (l_cur == PH_CH_BYTE && l_nxt == PH_CH_BYTE) ? r_idx + 1'b1 : '0;
        end
    end

    always_comb begin
        l_kind = 1'b0;
        l_cmd  = CMD_WR_EP0;
        l_data = 8'd0;
        case (l_cur)
            PH_EP_CMD:     l_cmd  = i_job.ep_cmd;
            PH_EP_DATA:    begin l_kind = 1'b1; l_data = i_job.ep_data; end
            PH_CH_CMD:     l_cmd  = CMD_WR_EP0;
            PH_CH_LEN:     begin l_kind = 1'b1; l_data = i_job.len; end
            PH_CH_BYTE:    begin l_kind = 1'b1; l_data = i_chunk[r_idx]; end
            PH_STALL_CMD:  l_cmd  = CMD_ENDP3;
            PH_STALL_DATA: begin l_kind = 1'b1; l_data = EP0_STALL; end
            PH_ADDR_CMD:   l_cmd  = CMD_SET_ADDR;
            PH_ADDR_DATA:  begin l_kind = 1'b1; l_data = i_job.addr; end
            PH_UNLOCK:     l_cmd  = CMD_UNLOCK;
            default:       l_cmd  = CMD_WR_EP0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= PH_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (l_adv) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_adv) begin
            r_kind  <= l_kind;
            r_cmd   <= l_cmd;
            r_data  <= l_data;
            r_last  <= (l_nxt == PH_IDLE);
            r_flags <= i_job.flags;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_kind    = r_kind;
    assign o_out_command = r_cmd;
    assign o_out_data    = r_data;
    assign o_out_last    = r_last;
    assign o_flags       = r_flags;

endmodule

// File: design/usb_control_request_responder.sv
// ----------------------------------------------------------------------------
// usb_control_request_responder
// Answers USB control requests with chip command and data writes.
// The first write of a request passes the job queue and the output register.
// Throughput: one write per cycle while the receiver is ready; a queued job
// gives 1 to EP0_PACKET+4 writes through the single write sequencer port.
// A two-entry job queue lets new requests enter while writes drain.
// Reset clears the decoder flags, pointers, lengths and the request buffer.
// ----------------------------------------------------------------------------
module usb_control_request_responder #(
    parameter int EP0_PACKET = ucrr_pkg::P_EP0_PACKET
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_req_type,
    input  logic [3:0] i_setup_count,
    input  logic [7:0] i_setup_byte0,
    input  logic [7:0] i_setup_byte1,
    input  logic [7:0] i_setup_byte2,
    input  logic [7:0] i_setup_byte3,
    input  logic [7:0] i_setup_byte4,
    input  logic [7:0] i_setup_byte5,
    input  logic [7:0] i_setup_byte6,
    input  logic [7:0] i_setup_byte7,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_out_kind,
    output logic [2:0] o_out_command,
    output logic [7:0] o_out_data,
    output logic       o_out_last,
    output logic       o_configured,
    output logic       o_error_sticky,
    output logic       o_report_pending
);
    import ucrr_pkg::*;

    logic                       accept, q_push, q_pop, q_empty, q_full;
    t_job                       f_job, q_job;
    logic [EP0_PACKET-1:0][7:0] f_chunk, q_chunk;
    logic [7:0][7:0]            in_bytes;
    t_flags                     flags;

    assign in_bytes = {i_setup_byte7, i_setup_byte6, i_setup_byte5, i_setup_byte4,
                       i_setup_byte3, i_setup_byte2, i_setup_byte1, i_setup_byte0};
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    ucrr_front #(.EP0_PACKET(EP0_PACKET)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_req_type(i_req_type), .i_setup_count(i_setup_count),
        .i_bytes(in_bytes), .o_push(q_push), .o_job(f_job), .o_chunk(f_chunk)
    );

    ucrr_queue #(.EP0_PACKET(EP0_PACKET)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_job(f_job),
        .i_chunk(f_chunk), .i_pop(q_pop), .o_job(q_job), .o_chunk(q_chunk),
        .o_empty(q_empty), .o_full(q_full)
    );

    ucrr_back #(.EP0_PACKET(EP0_PACKET)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(q_job), .i_chunk(q_chunk),
        .i_empty(q_empty), .o_pop(q_pop), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_out_kind(o_out_kind),
        .o_out_command(o_out_command), .o_out_data(o_out_data),
        .o_out_last(o_out_last), .o_flags(flags)
    );

    assign o_configured     = flags.cfg;
    assign o_error_sticky   = flags.err;
    assign o_report_pending = flags.rpt;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("Job pushed into a full queue.");

    a_pop_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("Job popped from an empty queue.");

    a_ep1_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == EV_EP1_OUT) |-> !q_push)
        else $error("An EP1 out request queued a job.");

    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out_valid && o_out_last))
        else $error("Job retired without a final write.");

endmodule

// File: bench/usb_control_request_responder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_control_request_responder_tb
// Drives controller events into the responder and checks every chip write
// against a behavioral predictor of the request handling and descriptor reads.
// ----------------------------------------------------------------------------
module usb_control_request_responder_tb;
    import ucrr_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [2:0] command;
        logic [7:0] data;
        logic       last;
        logic       cfg;
        logic       err;
        logic       rpt;
    } t_write;

    typedef struct {
        logic [2:0]  ev;
        logic [3:0]  cnt;
        logic [7:0]  b [8];
        logic        typed;
        int          n_typed;
        t_write      w0;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_req_type;
    logic [3:0] i_setup_count;
    logic [7:0] sb [8];
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_out_kind;
    logic [2:0] o_out_command;
    logic [7:0] o_out_data;
    logic       o_out_last;
    logic       o_configured;
    logic       o_error_sticky;
    logic       o_report_pending;

    usb_control_request_responder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_setup_count(i_setup_count),
        .i_setup_byte0(sb[0]), .i_setup_byte1(sb[1]), .i_setup_byte2(sb[2]),
        .i_setup_byte3(sb[3]), .i_setup_byte4(sb[4]), .i_setup_byte5(sb[5]),
        .i_setup_byte6(sb[6]), .i_setup_byte7(sb[7]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_kind(o_out_kind),
        .o_out_command(o_out_command), .o_out_data(o_out_data), .o_out_last(o_out_last),
        .o_configured(o_configured), .o_error_sticky(o_error_sticky),
        .o_report_pending(o_report_pending)
    );

    localparam logic [2:0] EV_EP0_OUT = 3'd2;
    localparam logic [2:0] EV_OTHER   = 3'd5;
    localparam logic [7:0] REQ_BOGUS  = 8'h33;

    logic [7:0] m_buf [P_EP0_PACKET];
    logic [7:0] m_remain;
    logic [1:0] m_sel;
    logic [7:0] m_off;
    logic [7:0] m_last_req;
    logic [7:0] m_addr;
    logic       m_err;
    logic       m_cfg;
    logic       m_rpt;

    t_write expected_writes [$];
    t_write pending [$];
    int     error_count;
    int     idle_pct;
    bit     hold_off;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [7:0] desc_byte(input logic [1:0] sel, input int off);
        logic [7:0] b;
        b = 8'h00;
        case (sel)
            SEL_DEV: if (off < 18) b = DEV_TAB[off];
            SEL_CFG: if (off < 34) b = CFG_TAB[off];
            SEL_HID: if (off < 65) b = HID_TAB[off];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    task automatic fetch_chunk();
        int nxt;
        for (int k = 0; k < P_EP0_PACKET; k++) begin
            m_buf[k] = desc_byte(m_sel, int'(m_off) + k);
        end
        nxt = int'(m_off) + P_EP0_PACKET;
        m_off = (nxt > 255) ? 8'd255 : nxt[7:0];
    endtask

    task automatic emit(input logic kind, input logic [2:0] cmd, input logic [7:0] d);
        t_write w;
        w = '0;
        w.kind = kind;
        w.command = cmd;
        w.data = d;
        pending.push_back(w);
    endtask

    task automatic emit_chunk();
        logic [7:0] len;
        len = 8'd0;
        if (m_remain != 8'd0) begin
            len = (m_remain <= P_EP0_PACKET) ? m_remain : 8'(P_EP0_PACKET);
            m_remain = m_remain - len;
        end
        emit(1'b0, CMD_WR_EP0, 8'h00);
        emit(1'b1, CMD_WR_EP0, len);
        for (int i = 0; i < len; i++) begin
            emit(1'b1, CMD_WR_EP0, m_buf[i]);
        end
    endtask

    task automatic decode_setup(input logic [3:0] cnt, input logic [7:0] b [8]);
        int stored;
        logic [7:0] b0, b1;
        stored = (cnt < 4'd8) ? int'(cnt) : 8;
        for (int i = 0; i < stored; i++) begin
            m_buf[i] = b[i];
        end
        if (cnt != 4'd8) begin
            m_err = 1'b1;
        end else begin
            b0 = m_buf[0];
            b1 = m_buf[1];
            m_remain = m_buf[6];
            if ((b0 & MASK_CLASS) != 0 && b1 == CLASS_SET_REP) m_rpt = 1'b1;
            if ((b0 & MASK_TYPE) == 0) begin
                m_last_req = b1;
                case (b1)
                    REQ_CLEAR_FEATURE: begin
                        if ((b0 & MASK_RECIP) == RECIP_ENDP) begin
                            case (m_buf[4])
                                EP_IN2: begin
                                    emit(1'b0, CMD_ENDP7, 8'h00);
                                    emit(1'b1, CMD_WR_EP0, EP_IN_CLEAR);
                                end
                                EP_OUT2: begin
                                    emit(1'b0, CMD_ENDP6, 8'h00);
                                    emit(1'b1, CMD_WR_EP0, EP_OUT_CLEAR);
                                end
                                EP_IN1: begin
                                    emit(1'b0, CMD_ENDP5, 8'h00);
                                    emit(1'b1, CMD_WR_EP0, EP_IN_CLEAR);
                                end
                                EP_OUT1: begin
                                    emit(1'b0, CMD_ENDP4, 8'h00);
                                    emit(1'b1, CMD_WR_EP0, EP_OUT_CLEAR);
                                end
                                default: ;
                            endcase
                        end else begin
                            m_err = 1'b1;
                        end
                    end
                    REQ_GET_STATUS: begin
                        m_buf[0] = 8'h00;
                        m_buf[1] = 8'h00;
                    end
                    REQ_SET_ADDRESS: m_addr = m_buf[2];
                    REQ_GET_DESC: begin
                        if (m_buf[3] == DT_DEVICE || m_buf[3] == DT_CONFIG ||
                            m_buf[3] == DT_REPORT) begin
                            m_sel = (m_buf[3] == DT_DEVICE) ? SEL_DEV :
                                    (m_buf[3] == DT_CONFIG) ? SEL_CFG : SEL_HID;
                            m_off = 8'd0;
                            fetch_chunk();
                        end else begin
                            m_err = 1'b1;
                        end
                    end
                    REQ_GET_CONFIG: m_buf[0] = {7'd0, m_cfg};
                    REQ_SET_CONFIG: m_cfg = (m_buf[2] != 8'd0);
                    REQ_GET_IFACE: m_buf[0] = 8'd1;
                    default: m_err = 1'b1;
                endcase
            end
        end
        if (!m_err) begin
            emit_chunk();
        end else begin
            emit(1'b0, CMD_ENDP3, 8'h00);
            emit(1'b1, CMD_WR_EP0, EP0_STALL);
        end
    endtask

    task automatic predict_event(input logic [2:0] ev, input logic [3:0] cnt,
                                 input logic [7:0] b [8]);
        t_write w;
        pending.delete();
        case (ev)
            EV_SETUP: decode_setup(cnt, b);
            EV_IN_DONE: begin
                if (m_last_req == REQ_GET_DESC) begin
                    fetch_chunk();
                    emit_chunk();
                end else if (m_last_req == REQ_SET_ADDRESS) begin
                    emit(1'b0, CMD_SET_ADDR, 8'h00);
                    emit(1'b1, CMD_WR_EP0, m_addr);
                end
                emit(1'b0, CMD_UNLOCK, 8'h00);
            end
            EV_EP1_OUT: ;
            EV_BUS_RESET: begin
                m_err = 1'b0;
                m_cfg = 1'b0;
                m_remain = 8'd0;
                emit(1'b0, CMD_UNLOCK, 8'h00);
            end
            default: emit(1'b0, CMD_UNLOCK, 8'h00);
        endcase
        for (int k = 0; k < pending.size(); k++) begin
            w = pending[k];
            w.last = (k == pending.size() - 1);
            w.cfg = m_cfg;
            w.err = m_err;
            w.rpt = m_rpt;
            expected_writes.push_back(w);
        end
    endtask

    // Drives one request and waits for its acceptance.
    task automatic send_request(input logic [2:0] ev, input logic [3:0] cnt,
                                input logic [7:0] b [8]);
        while (($urandom_range(99) < idle_pct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= ev;
        i_setup_count <= cnt;
        for (int i = 0; i < 8; i++) sb[i] <= b[i];
        do @(posedge i_clk); while (!o_in_ready);
        predict_event(ev, cnt, b);
    endtask

    always @(posedge i_clk) begin
        t_write got, exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_out_kind, o_out_command, o_out_data, o_out_last,
                   o_configured, o_error_sticky, o_report_pending};
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write %h", got));
            end else begin
                exp_w = expected_writes.pop_front();
                if (got.kind !== exp_w.kind) report_mismatch("out_kind");
                if (got.command !== exp_w.command) report_mismatch("out_command");
                if (got.data !== exp_w.data)
                    report_mismatch($sformatf("out_data %h exp %h", got.data, exp_w.data));
                if (got.last !== exp_w.last) report_mismatch("out_last");
                if (got.cfg !== exp_w.cfg) report_mismatch("configured");
                if (got.err !== exp_w.err) report_mismatch("error_sticky");
                if (got.rpt !== exp_w.rpt) report_mismatch("report_pending");
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_row make_row(input logic [2:0] ev, input logic [3:0] cnt,
                                      input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [7:0] b4, input logic [7:0] b6);
        t_row r;
        r.ev = ev;
        r.cnt = cnt;
        r.b = '{b0, b1, b2, b3, b4, 8'h00, b6, 8'hFF};
        r.typed = 1'b0;
        r.n_typed = 0;
        r.w0 = '0;
        return r;
    endfunction

    t_row rows [$];

    initial begin
        t_row r;
        logic [7:0] b [8];
        int n_exp;
        logic [2:0] ev;
        logic [7:0] req;
        error_count = 0;
        idle_pct = 20;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = '0;
        i_setup_count = '0;
        for (int i = 0; i < 8; i++) sb[i] = '0;
        for (int i = 0; i < P_EP0_PACKET; i++) m_buf[i] = '0;
        {m_remain, m_sel, m_off, m_last_req, m_addr, m_err, m_cfg, m_rpt} = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Typed rows: an unlock right after reset, a short setup that stalls.
        r = make_row(EV_OTHER, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        r.typed = 1'b1; r.n_typed = 1;
        r.w0 = '{1'b0, CMD_UNLOCK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0};
        rows.push_back(r);
        r = make_row(EV_SETUP, 4'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        r.typed = 1'b1; r.n_typed = 2;
        r.w0 = '{1'b0, CMD_ENDP3, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0};
        rows.push_back(r);
        rows.push_back(make_row(EV_SETUP, 4'd15, 8'h80, 8'h06, 8'h00, 8'h01, 8'h00, 8'hFF));
        rows.push_back(make_row(EV_BUS_RESET, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h80, REQ_GET_DESC, 8'h00, DT_DEVICE,
                                8'h00, 8'hFF));
        for (int i = 0; i < 3; i++)
            rows.push_back(make_row(EV_IN_DONE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h80, REQ_GET_DESC, 8'h00, DT_REPORT,
                                8'h00, 8'd255));
        for (int i = 0; i < 4; i++)
            rows.push_back(make_row(EV_IN_DONE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h00, REQ_SET_ADDRESS, 8'h7F, 8'h00,
                                8'h00, 8'h00));
        rows.push_back(make_row(EV_IN_DONE, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h00, REQ_SET_CONFIG, 8'h01, 8'h00,
                                8'h00, 8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h80, REQ_GET_CONFIG, 8'h00, 8'h00,
                                8'h00, 8'd1));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h80, REQ_GET_STATUS, 8'h00, 8'h00,
                                8'h00, 8'd2));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h81, REQ_GET_IFACE, 8'h00, 8'h00,
                                8'h00, 8'd1));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h02, REQ_CLEAR_FEATURE, 8'h00, 8'h00,
                                EP_IN1, 8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h02, REQ_CLEAR_FEATURE, 8'h00, 8'h00,
                                8'h05, 8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h21, CLASS_SET_REP, 8'h00, 8'h00,
                                8'h00, 8'h00));
        rows.push_back(make_row(EV_EP1_OUT, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00));
        rows.push_back(make_row(EV_EP0_OUT, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00));
        rows.push_back(make_row(3'd7, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        rows.push_back(make_row(EV_SETUP, 4'd8, 8'h00, REQ_BOGUS, 8'h00, 8'h00, 8'h00,
                                8'h00));

        foreach (rows[i]) begin
            r = rows[i];
            send_request(r.ev, r.cnt, r.b);
            if (r.typed) begin
                n_exp = expected_writes.size() - pending.size();
                if (pending.size() != r.n_typed) begin
                    report_mismatch("typed row write count");
                end else begin
                    if (expected_writes[n_exp] !== r.w0)
                        report_mismatch("typed row first write");
                    expected_writes[n_exp] = r.w0;
                end
            end
        end
        drain();

        // Random part: mostly well-formed control transfers with random content.
        for (int it = 0; it < 500; it++) begin
            idle_pct = (it >= 200 && it < 300) ? 0 : 20;
            if (it == 100) hold_off = 1'b1;
            if (it == 350) drain();
            for (int i = 0; i < 8; i++) b[i] = 8'($urandom_range(255));
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    ev = EV_SETUP;
                    case ($urandom_range(9))
                        0: req = REQ_GET_STATUS;
                        1: req = REQ_CLEAR_FEATURE;
                        2: req = REQ_SET_ADDRESS;
                        3, 4: req = REQ_GET_DESC;
                        5: req = REQ_GET_CONFIG;
                        6: req = REQ_SET_CONFIG;
                        7: req = REQ_GET_IFACE;
                        default: req = b[1];
                    endcase
                    b[1] = req;
                    if ($urandom_range(3) != 0) b[0] = b[0] & 8'h9F;
                    if (req == REQ_CLEAR_FEATURE && $urandom_range(1)) begin
                        b[0] = 8'h02;
                        case ($urandom_range(4))
                            0: b[4] = EP_IN2;
                            1: b[4] = EP_OUT2;
                            2: b[4] = EP_IN1;
                            3: b[4] = EP_OUT1;
                            default: ;
                        endcase
                    end
                    if (req == REQ_GET_DESC && $urandom_range(3) != 0) begin
                        case ($urandom_range(2))
                            0: b[3] = DT_DEVICE;
                            1: b[3] = DT_CONFIG;
                            default: b[3] = DT_REPORT;
                        endcase
                    end
                    if ($urandom_range(4) == 0) b[1] = CLASS_SET_REP;
                    send_request(ev, ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8, b);
                end
                5, 6, 7: send_request(EV_IN_DONE, 4'($urandom_range(15)), b);
                8: send_request(($urandom_range(1)) ? EV_BUS_RESET : EV_EP1_OUT,
                                4'($urandom_range(15)), b);
                default: send_request(3'($urandom_range(7)), 4'($urandom_range(15)), b);
            endcase
        end
        fork
            drain();
            begin
                repeat (20000) @(posedge i_clk);
                report_mismatch("writes still expected at end");
            end
        join_any
        disable fork;
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
design/ucrr_pkg.sv
design/ucrr_front.sv
design/ucrr_queue.sv
design/ucrr_back.sv
design/usb_control_request_responder.sv
bench/usb_control_request_responder_tb.sv
